// ===== rtl/salc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salc_pkg: shared types and constants of the LRU cache tag store
// Field widths, operation and outcome codes, register indexes, reset values
// and the saturating counter step.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;

    localparam int OP_W         = 2;
    localparam int ADDR_W       = 64;
    localparam int RES_W        = 2;
    localparam int CNT_W        = 32;
    localparam int STAMP_W      = 32;
    localparam int SET_BITS_W   = 3;
    localparam int BLOCK_BITS_W = 6;
    localparam int WAYS_W       = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 6;

    localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
    localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;
    localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_STORE  = 2'd1,
        OP_MODIFY = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [RES_W-1:0] {
        RES_HIT   = 2'd0,
        RES_FILL  = 2'd1,
        RES_EVICT = 2'd2
    } res_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS   = 2'd0,
        CFG_BLOCK_BITS = 2'd1,
        CFG_WAYS       = 2'd2
    } cfg_idx_t;

    // Counter step that sticks at the all-ones value.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        return (x == '1) ? x : x + CNT_W'(1);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/set_assoc_lru_cache_tags.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags: set-associative cache tag store, LRU replacement
// Looks up each load, store or modify address in a tag store held in one
// memory, walks the ways of the set one per cycle, and reports hit, fill or
// eviction together with saturating running counts.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Beat carries
//  --------  ---------  -------------------------  ---------------------------
//  item      in         item_valid / item_stall    operation, address
//  result    out        result_valid / result_st.  access_result, last, counts
//  cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
//  An access walks the ways of the set through the single read port of the
//  line memory (one way read and compared per cycle), then writes the chosen
//  line; a hit ends the walk early. A modify makes two such accesses, the
//  second starting once the result of the first is loaded.
//  After reset a clearing pass writes every line invalid, one line per cycle,
//  so no item is taken until all (2 ** MAX_SET_BITS) * MAX_WAYS lines (512
//  with the default sizes) are cleared; configuration writes are taken
//  throughout.
//  A stalled result holds the block in its write cycle until the beat leaves.
//
module set_assoc_lru_cache_tags #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [salc_pkg::CFG_DATA_W-1:0] cfg_data,

    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire logic [salc_pkg::OP_W-1:0]       operation,
    input  wire logic [salc_pkg::ADDR_W-1:0]     address,

    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic [salc_pkg::RES_W-1:0]           access_result,
    output logic                                last,
    output logic [salc_pkg::CNT_W-1:0]           hit_count,
    output logic [salc_pkg::CNT_W-1:0]           miss_count,
    output logic [salc_pkg::CNT_W-1:0]           eviction_count
);
    import salc_pkg::*;

    localparam int LINE_COUNT = (1 << MAX_SET_BITS) * MAX_WAYS;
    localparam int LINE_W     = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
    localparam int SET_W      = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W      = $clog2(MAX_WAYS + 1);
    localparam int WAY_IDX_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ENTRY_W    = 1 + ADDR_W + STAMP_W;
    localparam int SB_W       = 4;
    localparam int SHIFT_W    = 7;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_WRITE = 4'b1000
    } state_t;

    // Configuration registers.
    logic [SET_BITS_W-1:0]   set_bits_reg;
    logic [BLOCK_BITS_W-1:0] block_bits_reg;
    logic [WAYS_W-1:0]       ways_in_use_reg;

    // Sequencer and access context.
    state_t                  state_reg, state_next;
    logic [LINE_W-1:0]       clr_reg, clr_next;
    op_t                     op_reg, op_next;
    logic [ADDR_W-1:0]       tag_reg, tag_next;
    logic [SET_W-1:0]        set_reg, set_next;
    logic                    second_reg, second_next;

    // Way walk.
    logic [WAY_W-1:0]        way_reg, way_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic [WAY_IDX_W-1:0]    cmp_way_reg, cmp_way_next;
    logic                    inv_found_reg, inv_found_next;
    logic [WAY_IDX_W-1:0]    inv_way_reg, inv_way_next;
    logic [WAY_IDX_W-1:0]    min_way_reg, min_way_next;
    logic [STAMP_W-1:0]      min_stamp_reg, min_stamp_next;
    logic [WAY_IDX_W-1:0]    victim_reg, victim_next;
    res_t                    res_reg, res_next;

    // Running state and the result register.
    logic [STAMP_W-1:0]      stamp_reg, stamp_next;
    logic [CNT_W-1:0]        hits_reg, hits_next;
    logic [CNT_W-1:0]        misses_reg, misses_next;
    logic [CNT_W-1:0]        evicts_reg, evicts_next;
    logic                    result_valid_reg, result_valid_next;
    res_t                    access_result_reg, access_result_next;
    logic                    last_reg, last_next;

    // Line memory: {valid, tag, stamp} at entry set * MAX_WAYS + way.
    logic [ENTRY_W-1:0]      line_mem [LINE_COUNT];
    logic [ENTRY_W-1:0]      rd_data_reg;
    logic [LINE_W-1:0]       rd_idx;
    logic [LINE_W-1:0]       wr_idx;
    logic [ENTRY_W-1:0]      wr_data;
    logic                    mem_we;

    // Effective geometry and address split of the incoming beat.
    logic [SB_W-1:0]         sb_eff;
    logic [SHIFT_W-1:0]      shift_sum;
    logic [ADDR_W-1:0]       addr_sh;
    logic [ADDR_W-1:0]       tag_c;
    logic [SET_W-1:0]        set_mask;
    logic [SET_W-1:0]        set_c;
    logic [WAYS_W:0]         ways_ext;
    logic [WAY_W-1:0]        ways_eff;

    // Per-way compare.
    logic                    ent_valid;
    logic [ADDR_W-1:0]       ent_tag;
    logic [STAMP_W-1:0]      ent_stamp;
    logic                    hit_c;
    logic                    last_way_c;
    logic                    scan_done_c;
    logic                    inv_found_c;
    logic [WAY_IDX_W-1:0]    inv_way_c;
    logic                    take_min_c;
    logic [WAY_IDX_W-1:0]    min_way_c;
    logic [STAMP_W-1:0]      min_stamp_c;
    logic                    issue_c;
    logic [LINE_W-1:0]       line_base;
    logic                    item_accept;
    logic                    out_free;
    logic                    result_load_c;

    assign cfg_ready      = 1'b1;
    assign item_stall     = (state_reg != S_IDLE);
    assign item_accept    = item_valid && !item_stall;

    assign result_valid   = result_valid_reg;
    assign access_result  = access_result_reg;
    assign last           = last_reg;
    // The counters change only when a new result is loaded, which waits for
    // the result register to be free, so they serve as the count fields.
    assign hit_count      = hits_reg;
    assign miss_count     = misses_reg;
    assign eviction_count = evicts_reg;

    // Set index bits beyond the implemented maximum are ignored.
    assign sb_eff    = (SB_W'(set_bits_reg) > SB_W'(MAX_SET_BITS)) ?
                       SB_W'(MAX_SET_BITS) : SB_W'(set_bits_reg);
    assign shift_sum = SHIFT_W'(sb_eff) + SHIFT_W'(block_bits_reg);
    assign addr_sh   = address >> block_bits_reg;
    assign tag_c     = (shift_sum >= SHIFT_W'(ADDR_W)) ? '0 :
                       (address >> shift_sum[SHIFT_W-2:0]);
    assign set_mask  = ~({SET_W{1'b1}} << sb_eff);
    assign set_c     = addr_sh[SET_W-1:0] & set_mask;

    // Associativity is clamped to the range the store implements.
    assign ways_ext  = {1'b0, ways_in_use_reg};
    always_comb
    begin
        if (ways_ext == '0)
        begin
            ways_eff = WAY_W'(1);
        end
        else if (ways_ext > (WAYS_W + 1)'(MAX_WAYS))
        begin
            ways_eff = WAY_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WAY_W'(ways_ext);
        end
    end

    // Compare of the way read in the previous cycle. The oldest stamp is
    // tracked over every way; it only matters when all ways are valid.
    assign ent_valid   = rd_data_reg[ENTRY_W-1];
    assign ent_tag     = rd_data_reg[STAMP_W +: ADDR_W];
    assign ent_stamp   = rd_data_reg[STAMP_W-1:0];
    assign hit_c       = cmp_vld_reg && ent_valid && (ent_tag == tag_reg);
    assign last_way_c  = (WAY_W'(cmp_way_reg) == (ways_eff - WAY_W'(1)));
    assign scan_done_c = cmp_vld_reg && (hit_c || last_way_c);
    assign inv_found_c = inv_found_reg || !ent_valid;
    assign inv_way_c   = inv_found_reg ? inv_way_reg : cmp_way_reg;
    assign take_min_c  = (cmp_way_reg == '0) || (ent_stamp < min_stamp_reg);
    assign min_way_c   = take_min_c ? cmp_way_reg : min_way_reg;
    assign min_stamp_c = take_min_c ? ent_stamp : min_stamp_reg;

    // One way of the set is read per cycle while the walk is open.
    assign issue_c   = (state_reg == S_SCAN) && (way_reg < ways_eff);
    assign line_base = LINE_W'(LINE_W'(set_reg) * LINE_W'(MAX_WAYS));
    assign rd_idx    = line_base + (issue_c ? LINE_W'(way_reg[WAY_IDX_W-1:0]) : '0);

    assign out_free      = !result_valid_reg || !result_stall;
    assign result_load_c = (state_reg == S_WRITE) && out_free;

    always_comb
    begin
        state_next         = state_reg;
        clr_next           = clr_reg;
        op_next            = op_reg;
        tag_next           = tag_reg;
        set_next           = set_reg;
        second_next        = second_reg;
        way_next           = way_reg;
        cmp_vld_next       = 1'b0;
        cmp_way_next       = cmp_way_reg;
        inv_found_next     = inv_found_reg;
        inv_way_next       = inv_way_reg;
        min_way_next       = min_way_reg;
        min_stamp_next     = min_stamp_reg;
        victim_next        = victim_reg;
        res_next           = res_reg;
        stamp_next         = stamp_reg;
        hits_next          = hits_reg;
        misses_next        = misses_reg;
        evicts_next        = evicts_reg;
        result_valid_next  = result_valid_reg && result_stall;
        access_result_next = access_result_reg;
        last_next          = last_reg;
        mem_we             = 1'b0;
        wr_idx             = line_base + LINE_W'(victim_reg);
        wr_data            = {1'b1, tag_reg, stamp_reg};

        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                wr_idx   = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + LINE_W'(1);
                if (clr_reg == LINE_W'(LINE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                // The no-operation code is taken and dropped.
                if (item_accept && (op_t'(operation) != OP_NONE))
                begin
                    op_next        = op_t'(operation);
                    tag_next       = tag_c;
                    set_next       = set_c;
                    second_next    = 1'b0;
                    way_next       = '0;
                    inv_found_next = 1'b0;
                    state_next     = S_SCAN;
                end
            end

            S_SCAN:
            begin
                cmp_vld_next = issue_c;
                cmp_way_next = way_reg[WAY_IDX_W-1:0];
                if (issue_c)
                begin
                    way_next = way_reg + WAY_W'(1);
                end
                if (cmp_vld_reg)
                begin
                    inv_found_next = inv_found_c;
                    inv_way_next   = inv_way_c;
                    min_way_next   = min_way_c;
                    min_stamp_next = min_stamp_c;
                end
                if (scan_done_c)
                begin
                    state_next = S_WRITE;
                    if (hit_c)
                    begin
                        victim_next = cmp_way_reg;
                        res_next    = RES_HIT;
                    end
                    else if (inv_found_c)
                    begin
                        victim_next = inv_way_c;
                        res_next    = RES_FILL;
                    end
                    else
                    begin
                        victim_next = min_way_c;
                        res_next    = RES_EVICT;
                    end
                end
            end

            S_WRITE:
            begin
                if (out_free)
                begin
                    // A hit rewrites the same valid bit and tag with a new stamp.
                    mem_we             = 1'b1;
                    stamp_next         = stamp_reg + STAMP_W'(1);
                    result_valid_next  = 1'b1;
                    access_result_next = res_reg;
                    last_next          = (op_reg != OP_MODIFY) || second_reg;
                    if (res_reg == RES_HIT)
                    begin
                        hits_next = sat_inc(hits_reg);
                    end
                    else
                    begin
                        misses_next = sat_inc(misses_reg);
                    end
                    if (res_reg == RES_EVICT)
                    begin
                        evicts_next = sat_inc(evicts_reg);
                    end
                    if ((op_reg == OP_MODIFY) && !second_reg)
                    begin
                        second_next    = 1'b1;
                        way_next       = '0;
                        inv_found_next = 1'b0;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg      <= SET_BITS_RST;
            block_bits_reg    <= BLOCK_BITS_RST;
            ways_in_use_reg   <= WAYS_RST;
            state_reg         <= S_CLEAR;
            clr_reg           <= '0;
            second_reg        <= 1'b0;
            way_reg           <= '0;
            cmp_vld_reg       <= 1'b0;
            inv_found_reg     <= 1'b0;
            stamp_reg         <= '0;
            hits_reg          <= '0;
            misses_reg        <= '0;
            evicts_reg        <= '0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SET_BITS:   set_bits_reg    <= cfg_data[SET_BITS_W-1:0];
                    CFG_BLOCK_BITS: block_bits_reg  <= cfg_data[BLOCK_BITS_W-1:0];
                    CFG_WAYS:       ways_in_use_reg <= cfg_data[WAYS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            state_reg         <= state_next;
            clr_reg           <= clr_next;
            second_reg        <= second_next;
            way_reg           <= way_next;
            cmp_vld_reg       <= cmp_vld_next;
            inv_found_reg     <= inv_found_next;
            stamp_reg         <= stamp_next;
            hits_reg          <= hits_next;
            misses_reg        <= misses_next;
            evicts_reg        <= evicts_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    // Access context and result payload.
    always_ff @(posedge clk)
    begin
        op_reg            <= op_next;
        tag_reg           <= tag_next;
        set_reg           <= set_next;
        cmp_way_reg       <= cmp_way_next;
        inv_way_reg       <= inv_way_next;
        min_way_reg       <= min_way_next;
        min_stamp_reg     <= min_stamp_next;
        victim_reg        <= victim_next;
        res_reg           <= res_next;
        access_result_reg <= access_result_next;
        last_reg          <= last_next;
    end

    // Line memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= line_mem[rd_idx];
    end

    // Every eviction is also counted as a miss.
    a_evict_le_miss: assert property (@(posedge clk) disable iff (!rst_n)
        evicts_reg <= misses_reg)
        else $error("eviction count exceeds miss count");

    // Each reported access advances the stamp by exactly one.
    a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_load_c |=> (stamp_reg == $past(stamp_reg) + STAMP_W'(1)))
        else $error("access stamp did not advance with a result");

    // The hit count never goes backward.
    a_hits_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (hits_reg >= $past(hits_reg)))
        else $error("hit count decreased");

    // Once the first half of a modify leaves, the second access is under way
    // or its result has just been loaded in the same cycle.
    a_modify_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_stall && !last_reg)
        |=> ((state_reg == S_SCAN) || (state_reg == S_WRITE) || last_reg))
        else $error("second access of a modify not in progress");

    // No result appears while the store is being cleared.
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !result_valid_reg)
        else $error("result beat during clearing pass");

endmodule
`default_nettype wire
